@@ hw/rtl/ats_pkg.sv @@
package ats_pkg;

  // character codes the scanner reacts to
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_VT    = 8'd11;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_HASH  = 8'd35;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // defaults for the top-level parameters
  localparam int DEF_MAX_TOKEN_LEN = 255;
  localparam int DEF_LINE_BITS     = 16;

  // depth of the queue between classifier and scanner
  localparam int QUEUE_DEPTH = 4;

  localparam int NUM_KW     = 4;
  localparam int OUT_LINE_W = 16;

  typedef enum logic [1:0] {
    TT_NUMBER = 2'd0,
    TT_INSTR  = 2'd1,
    TT_ERROR  = 2'd2,
    TT_END    = 2'd3
  } tok_type_t;

  typedef enum logic [1:0] {
    KW_NOP  = 2'd0,
    KW_PUSH = 2'd1,
    KW_ADD  = 2'd2,
    KW_HLT  = 2'd3
  } kw_code_t;

  // one classified source byte
  typedef struct packed {
    logic [7:0] code;
    logic       is_end;
    logic       is_delim;
    logic       is_newline;
    logic       is_digit;
    logic       is_blank;
    logic       is_sign;
    logic       is_minus;
    logic       is_hash;
  } char_class_t;

  function automatic logic [2:0] kw_len(input kw_code_t k);
    logic [2:0] len;
    unique case (k)
      KW_NOP:  len = 3'd3;
      KW_PUSH: len = 3'd4;
      KW_ADD:  len = 3'd3;
      KW_HLT:  len = 3'd3;
      default: len = 3'd3;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input kw_code_t k, input logic [1:0] idx);
    logic [31:0] txt;
    unique case (k)
      KW_NOP:  txt = {8'd0, "P", "O", "N"};
      KW_PUSH: txt = {"H", "S", "U", "P"};
      KW_ADD:  txt = {8'd0, "D", "D", "A"};
      KW_HLT:  txt = {8'd0, "T", "L", "H"};
      default: txt = 32'd0;
    endcase
    return txt[idx*8 +: 8];
  endfunction

endpackage

@@ hw/rtl/ats_front.sv @@
module ats_front
  import ats_pkg::*;
(
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        q_full,
  output logic        q_push,
  output char_class_t q_data
);

  logic [7:0] c;

  assign c        = in_char_code;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.code       = c;
    q_data.is_end     = (c == CHAR_NUL);
    q_data.is_newline = (c == CHAR_NL);
    q_data.is_delim   = (c == CHAR_NUL) || (c == CHAR_NL) || (c == CHAR_SPACE);
    q_data.is_digit   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    q_data.is_blank   = (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF) ||
                        (c == CHAR_CR);
    q_data.is_sign    = (c == CHAR_PLUS) || (c == CHAR_MINUS);
    q_data.is_minus   = (c == CHAR_MINUS);
    q_data.is_hash    = (c == CHAR_HASH);
  end

endmodule

@@ hw/rtl/ats_queue.sv @@
module ats_queue
  import ats_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  char_class_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        q_valid,
  output char_class_t q_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  char_class_t         entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("queue count did not drop on pop");

endmodule

@@ hw/rtl/ats_back.sv @@
module ats_back
  import ats_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
  parameter int LINE_BITS     = DEF_LINE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  char_class_t            q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_token_type,
  output logic signed [31:0]     out_token_value,
  output logic [OUT_LINE_W-1:0]  out_line_number,
  output logic                   out_last
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 2);

  typedef enum logic [2:0] {
    PH_SKIP   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  is_num_r, is_num_nxt;
  phase_t                phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic [NUM_KW-1:0]     cand_r, cand_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt;
  logic                  halted_r, halted_nxt;

  logic                  out_valid_r, out_valid_nxt;
  tok_type_t             type_r, type_nxt;
  logic [31:0]           value_r, value_nxt;
  logic [OUT_LINE_W-1:0] oline_r, oline_nxt;
  logic                  last_r, last_nxt;

  logic                            take;
  logic [31:0]                     acc_step;
  logic [LINE_BITS+OUT_LINE_W-1:0] line_ext;
  tok_type_t                       res_type;
  logic [31:0]                     res_value;
  logic                            found;
  logic                            emit;

  assign take     = q_valid && (!out_valid_r || !out_stall);
  assign q_pop    = take;
  assign acc_step = (acc_r << 3) + (acc_r << 1) + {28'd0, q_data.code[3:0]};
  assign line_ext = {{OUT_LINE_W{1'b0}}, line_r};

  assign out_valid       = out_valid_r;
  assign out_token_type  = type_r;
  assign out_token_value = value_r;
  assign out_line_number = oline_r;
  assign out_last        = last_r;

  // token result as of the delimiter
  always_comb begin
    res_type  = TT_ERROR;
    res_value = '0;
    found     = 1'b0;
    if (len_r == '0) begin
      res_type = TT_END;
    end else if (len_r > LEN_W'(MAX_TOKEN_LEN)) begin
      res_type = TT_ERROR;
    end else if (is_num_r) begin
      res_type  = TT_NUMBER;
      res_value = neg_r ? (32'd0 - acc_r) : acc_r;
    end else begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (!found && cand_r[k] && (len_r == LEN_W'(kw_len(kw_code_t'(k))))) begin
          found     = 1'b1;
          res_type  = TT_INSTR;
          res_value = 32'(k);
        end
      end
    end
  end

  always_comb begin
    len_nxt       = len_r;
    is_num_nxt    = is_num_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    cand_nxt      = cand_r;
    line_nxt      = line_r;
    halted_nxt    = halted_r;
    out_valid_nxt = out_valid_r && out_stall;
    type_nxt      = type_r;
    value_nxt     = value_r;
    oline_nxt     = oline_r;
    last_nxt      = last_r;
    emit          = 1'b0;

    if (take) begin
      if (halted_r) begin
        if (q_data.is_end) begin
          len_nxt    = '0;
          is_num_nxt = 1'b0;
          phase_nxt  = PH_SKIP;
          neg_nxt    = 1'b0;
          acc_nxt    = '0;
          cand_nxt   = '1;
          line_nxt   = '0;
          halted_nxt = 1'b0;
        end
      end else if (!q_data.is_delim) begin
        if (len_r == '0) begin
          is_num_nxt = q_data.is_hash;
        end else if (is_num_r) begin
          unique case (phase_r)
            PH_SKIP: begin
              if (!q_data.is_blank) begin
                priority if (q_data.is_sign) begin
                  neg_nxt   = q_data.is_minus;
                  phase_nxt = PH_DIGITS;
                end else if (!q_data.is_digit) begin
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_DIGITS;
                  acc_nxt   = acc_step;
                end
              end
            end
            PH_DIGITS: begin
              if (q_data.is_digit) begin
                acc_nxt = acc_step;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            PH_DONE: begin
              phase_nxt = PH_DONE;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
        for (int k = 0; k < NUM_KW; k++) begin
          if (!((len_r < LEN_W'(kw_len(kw_code_t'(k)))) &&
                (kw_char(kw_code_t'(k), len_r[1:0]) == q_data.code))) begin
            cand_nxt[k] = 1'b0;
          end
        end
        if (len_r <= LEN_W'(MAX_TOKEN_LEN)) begin
          len_nxt = len_r + LEN_W'(1);
        end
      end else begin
        emit = (len_r != '0) || q_data.is_end;
        if (emit) begin
          out_valid_nxt = 1'b1;
          type_nxt      = res_type;
          value_nxt     = res_value;
          oline_nxt     = line_ext[OUT_LINE_W-1:0];
          last_nxt      = q_data.is_end || (res_type == TT_ERROR);
        end
        len_nxt    = '0;
        is_num_nxt = 1'b0;
        phase_nxt  = PH_SKIP;
        neg_nxt    = 1'b0;
        acc_nxt    = '0;
        cand_nxt   = '1;
        if (q_data.is_newline && (line_r != {LINE_BITS{1'b1}})) begin
          line_nxt = line_r + LINE_BITS'(1);
        end
        if (emit && (res_type == TT_ERROR) && !q_data.is_end) begin
          halted_nxt = 1'b1;
        end
        if (q_data.is_end) begin
          line_nxt   = '0;
          halted_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      is_num_r    <= 1'b0;
      phase_r     <= PH_SKIP;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      cand_r      <= '1;
      line_r      <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      is_num_r    <= is_num_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      cand_r      <= cand_nxt;
      line_r      <= line_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r  <= type_nxt;
    value_r <= value_nxt;
    oline_r <= oline_nxt;
    last_r  <= last_nxt;
  end

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (type_r == TT_ERROR)) |-> last_r)
    else $error("error result without last");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_data.is_end && !halted_r) |=> (out_valid_r && last_r))
    else $error("end of text gave no last result");

  a_halted_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (len_r == '0))
    else $error("token bytes collected while halted");

endmodule

@@ hw/rtl/assembly_token_scanner_core.sv @@
// assembly token scanner
// in_*:  one source byte per word (in_char_code); space, newline and nul end
//        a token, nul also ends the source text
// out_*: one result word per token: type, value, line number and last flag;
//        a nul with no token before it gives an end word with last set
// a word moves on a channel at a rising edge where valid is high and stall
// is low
// the front classifies each accepted byte and writes it to a four-word
// queue; the back scanner pops one byte per cycle and updates the token
// state (one multiply-by-ten accumulate or one compare set per byte)
// throughput: one byte per cycle, sustained, while out_stall stays low
// a delimiter byte is written to the queue, popped by the back scanner, and
// its result is registered, after the bytes queued ahead of it are scanned
// stall: the result register holds its word while out_stall is high, the
// scanner stops popping, the queue fills and in_stall rises once four
// words are queued
// after an error result the back drops bytes up to and including the next
// nul, which re-arms the scanner
// reset (rst_n low, synchronous) empties the queue, clears the token state
// and the line counter and drops any pending result word
module assembly_token_scanner_core
  import ats_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
  parameter int LINE_BITS     = DEF_LINE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char_code,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_token_type,
  output logic signed [31:0]    out_token_value,
  output logic [OUT_LINE_W-1:0] out_line_number,
  output logic                  out_last
);

  // front to queue
  logic        q_full;
  logic        q_push;
  char_class_t q_push_data;

  // queue to back
  logic        q_valid;
  logic        q_pop;
  char_class_t q_head;

  // classify bytes and own the input handshake
  ats_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_push_data)
  );

  // decouples input stalls from result stalls
  ats_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_head)
  );

  // token scanner with registered result word
  ats_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .LINE_BITS     (LINE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_type  (out_token_type),
    .out_token_value (out_token_value),
    .out_line_number (out_line_number),
    .out_last        (out_last)
  );

endmodule
